>>> rtl/phot_pkg.sv
`timescale 1ns / 1ps
package phot_pkg;
  localparam int Dim = 7;
  localparam int Rate = 9;
  localparam int Rounds = 12;
  localparam logic [3:0] PadNibble = 4'h8;

  typedef logic [3:0] nib_t;
  typedef nib_t [Dim-1:0] col_t;

  // Control broadcast along the row of column cells.
  typedef struct packed {
    logic       load_iv;
    logic       absorb;
    logic       round_en;
  } cell_ctl_t;

  function automatic nib_t sbox(input nib_t x);
    nib_t r;
    case (x)
      4'h0: r = 4'hc; 4'h1: r = 4'h5; 4'h2: r = 4'h6; 4'h3: r = 4'hb;
      4'h4: r = 4'h9; 4'h5: r = 4'h0; 4'h6: r = 4'ha; 4'h7: r = 4'hd;
      4'h8: r = 4'h3; 4'h9: r = 4'he; 4'ha: r = 4'hf; 4'hb: r = 4'h8;
      4'hc: r = 4'h4; 4'hd: r = 4'h7; 4'he: r = 4'h1; default: r = 4'h2;
    endcase
    return r;
  endfunction

  function automatic nib_t round_const(input logic [3:0] r);
    nib_t c;
    case (r)
      4'd0: c = 4'd1;  4'd1: c = 4'd3;  4'd2: c = 4'd7;   4'd3: c = 4'd14;
      4'd4: c = 4'd13; 4'd5: c = 4'd11; 4'd6: c = 4'd6;   4'd7: c = 4'd12;
      4'd8: c = 4'd9;  4'd9: c = 4'd2;  4'd10: c = 4'd5;  default: c = 4'd10;
    endcase
    return c;
  endfunction

  localparam nib_t RowConst [Dim] = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd3, 4'd6, 4'd4};
  localparam nib_t IvRow [Dim] = '{4'd0, 4'd2, 4'd8, 4'd2, 4'd4, 4'd2, 4'd4};
  localparam nib_t Mix [Dim][Dim] = '{
    '{4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd6, 4'd4},
    '{4'd4, 4'd2, 4'd15, 4'd2, 4'd5, 4'd10, 4'd5},
    '{4'd5, 4'd3, 4'd15, 4'd10, 4'd7, 4'd8, 4'd13},
    '{4'd13, 4'd4, 4'd11, 4'd2, 4'd7, 4'd15, 4'd9},
    '{4'd9, 4'd15, 4'd7, 4'd2, 4'd11, 4'd4, 4'd13},
    '{4'd13, 4'd8, 4'd7, 4'd10, 4'd15, 4'd3, 4'd5},
    '{4'd5, 4'd10, 4'd5, 4'd2, 4'd15, 4'd2, 4'd4}};

  function automatic nib_t gf_mul(input nib_t a, input nib_t b);
    nib_t r;
    nib_t x;
    r = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r = r ^ x;
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return r;
  endfunction
endpackage

>>> rtl/photon160_sponge_hash.sv
`timescale 1ns / 1ps
// Channel  Dir  Ports
// in_      in   in_valid, in_stall, in_block_data, in_nibble_count, in_is_last
// out_     out  out_valid, out_stall, out_digest_chunk, out_chunk_nibbles, out_last_chunk
// One permutation round per cycle in a row of seven column cells: a block
// is taken in IDLE, absorbed in ABS and then permuted in PERM.
// A full last block adds a pad block, absorbed in PAD and permuted in PERM.
// Each chunk is loaded in SQZ and handed over in WAIT; PERM runs between chunks.
// Reset reloads the IV; each chunk waits in the output register
// while out_stall is high, and no new transaction is taken until the digest ends.
module photon160_sponge_hash #(
  parameter int DIGEST_NIBBLES = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [35:0] in_block_data,
  input  logic [3:0]  in_nibble_count,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [35:0] out_digest_chunk,
  output logic [3:0]  out_chunk_nibbles,
  output logic        out_last_chunk
);
  import phot_pkg::*;

  localparam int NChunks = (DIGEST_NIBBLES + Rate - 1) / Rate;
  localparam int LastN = DIGEST_NIBBLES - (NChunks - 1) * Rate;

  typedef enum logic [2:0] {IDLE, ABS, PERM, PAD, SQZ, WAIT} state_t;
  state_t state_r;
  logic [3:0] round_r;
  logic [2:0] chunk_r;
  logic last_r, pad_pending_r;
  logic [3:0] cnt_r;
  logic [35:0] blk_r;

  col_t cols [Dim];
  col_t subs [Dim];
  col_t shifted [Dim];
  col_t absorb_col [Dim];
  col_t iv_cols [Dim];
  col_t ac_cols [Dim];
  cell_ctl_t ctl;

  logic [35:0] pad_blk;
  always_comb begin
    pad_blk = '0;
    for (int p = 0; p < Rate; p++) begin
      if (p < int'(cnt_r)) pad_blk[35-4*p -: 4] = blk_r[35-4*p -: 4];
      else if (p == int'(cnt_r)) pad_blk[35-4*p -: 4] = PadNibble;
    end
  end

  always_comb begin
    for (int j = 0; j < Dim; j++) begin
      for (int i = 0; i < Dim; i++) begin
        absorb_col[j][i] = '0;
        iv_cols[j][i] = (i == Dim - 1) ? IvRow[j] : 4'h0;
        shifted[j][i] = subs[(j + i) % Dim][i];
      end
      absorb_col[j][0] = pad_blk[35-4*j -: 4];
    end
    absorb_col[0][1] = pad_blk[7:4];
    absorb_col[1][1] = pad_blk[3:0];
  end

  // AddConstant is applied before the S-box of column 0.
  always_comb begin
    for (int j = 0; j < Dim; j++) begin
      for (int i = 0; i < Dim; i++) begin
        ac_cols[j][i] = (j == 0) ? (round_const(round_r) ^ RowConst[i]) : 4'h0;
      end
    end
  end

  for (genvar j = 0; j < Dim; j++) begin : g_cell
    phot_cell u_cell (
      .clk(clk), .ctl(ctl), .col_in(shifted[j]), .absorb_in(absorb_col[j]),
      .iv_col(iv_cols[j]), .ac_in(ac_cols[j]), .sub_out(subs[j]), .col_r(cols[j]));
  end

  always_comb begin
    ctl.load_iv = !rst_n || (state_r == WAIT && !out_stall && out_valid && out_last_chunk);
    ctl.absorb = (state_r == ABS) || (state_r == PAD);
    ctl.round_en = (state_r == PERM);
  end

  assign in_stall = (state_r != IDLE);

  logic [35:0] chunk;
  always_comb begin
    chunk = '0;
    for (int j = 0; j < Dim; j++) chunk[35-4*j -: 4] = cols[j][0];
    chunk[7:4] = cols[0][1];
    chunk[3:0] = cols[1][1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      out_valid <= 1'b0;
      round_r <= '0;
      chunk_r <= '0;
    end else begin
      unique case (state_r)
        IDLE: if (in_valid) begin
          blk_r <= in_block_data;
          last_r <= in_is_last;
          if (!in_is_last || in_nibble_count >= 4'd9) begin
            cnt_r <= 4'd9;
            pad_pending_r <= in_is_last;
          end else begin
            cnt_r <= in_nibble_count;
            pad_pending_r <= 1'b0;
          end
          chunk_r <= '0;
          state_r <= ABS;
        end
        ABS, PAD: begin
          round_r <= '0;
          state_r <= PERM;
        end
        PERM: begin
          if (round_r == 4'(Rounds - 1)) begin
            round_r <= '0;
            if (pad_pending_r) begin
              pad_pending_r <= 1'b0;
              cnt_r <= '0;
              state_r <= PAD;
            end else if (!last_r) state_r <= IDLE;
            else state_r <= SQZ;
          end else round_r <= round_r + 4'd1;
        end
        SQZ: begin
          out_valid <= 1'b1;
          if (chunk_r == 3'(NChunks - 1)) begin
            out_digest_chunk <= chunk & ({36{1'b1}} << (4 * (Rate - LastN)));
            out_chunk_nibbles <= 4'(LastN);
            out_last_chunk <= 1'b1;
          end else begin
            out_digest_chunk <= chunk;
            out_chunk_nibbles <= 4'(Rate);
            out_last_chunk <= 1'b0;
          end
          state_r <= WAIT;
        end
        WAIT: if (!out_stall) begin
          out_valid <= 1'b0;
          if (out_last_chunk) state_r <= IDLE;
          else begin
            chunk_r <= chunk_r + 3'd1;
            last_r <= 1'b1;
            state_r <= PERM;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end
endmodule

>>> rtl/phot_cell.sv
`timescale 1ns / 1ps
// One state column. ShiftRows is a fixed wiring: row i of this column takes
// row i of its neighbour i places to the right, which arrives on col_in.
module phot_cell (
  input  logic               clk,
  input  phot_pkg::cell_ctl_t ctl,
  input  phot_pkg::col_t     col_in,
  input  phot_pkg::col_t     absorb_in,
  input  phot_pkg::col_t     iv_col,
  input  phot_pkg::col_t     ac_in,
  output phot_pkg::col_t     sub_out,
  output phot_pkg::col_t     col_r
);
  import phot_pkg::*;

  col_t col_nxt;
  col_t mixed;

  // AddConstant touches column 0 only; the top level feeds zeros elsewhere.
  always_comb begin
    for (int i = 0; i < Dim; i++) begin
      sub_out[i] = sbox(col_r[i] ^ ac_in[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < Dim; i++) begin
      mixed[i] = '0;
      for (int k = 0; k < Dim; k++) begin
        mixed[i] = mixed[i] ^ gf_mul(Mix[i][k], col_in[k]);
      end
    end
  end

  always_comb begin
    col_nxt = col_r;
    if (ctl.load_iv) col_nxt = iv_col;
    else if (ctl.absorb) col_nxt = col_r ^ absorb_in;
    else if (ctl.round_en) col_nxt = mixed;
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end
endmodule

>>> tb/photon160_sponge_hash_test.sv
`timescale 1ns / 1ps
module photon160_sponge_hash_test;
  import phot_pkg::*;

  typedef struct {
    logic [35:0] chunk;
    logic [3:0]  nibbles;
    logic        last;
  } digest_chunk_t;

  // Tracks the sponge state and the digest chunks still owed by the block.
  class digest_scoreboard;
    logic [3:0] cells [49];
    digest_chunk_t pending [$];
    int errors;

    function void load_iv();
      foreach (cells[i]) cells[i] = (i >= 42) ? IvRow[i - 42] : 4'd0;
    endfunction

    function logic [3:0] mul16(logic [3:0] a, logic [3:0] b);
      logic [3:0] r;
      logic [3:0] x;
      r = 0;
      x = a;
      for (int i = 0; i < 4; i++) begin
        if (b[i]) r ^= x;
        x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
      end
      return r;
    endfunction

    function void permute();
      logic [3:0] rcs [12];
      logic [3:0] sbx [16];
      logic [3:0] t [7];
      logic [3:0] s;
      rcs = '{1, 3, 7, 14, 13, 11, 6, 12, 9, 2, 5, 10};
      sbx = '{4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
              4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2};
      for (int r = 0; r < 12; r++) begin
        for (int i = 0; i < 7; i++) cells[i * 7] ^= rcs[r] ^ RowConst[i];
        foreach (cells[i]) cells[i] = sbx[cells[i]];
        for (int i = 1; i < 7; i++) begin
          for (int j = 0; j < 7; j++) t[j] = cells[i * 7 + j];
          for (int j = 0; j < 7; j++) cells[i * 7 + j] = t[(j + i) % 7];
        end
        for (int j = 0; j < 7; j++) begin
          for (int i = 0; i < 7; i++) begin
            s = 0;
            for (int k = 0; k < 7; k++) s ^= mul16(Mix[i][k], cells[k * 7 + j]);
            t[i] = s;
          end
          for (int i = 0; i < 7; i++) cells[i * 7 + j] = t[i];
        end
      end
    endfunction

    function void absorb(logic [3:0] blk [9]);
      for (int p = 0; p < 9; p++) cells[p] ^= blk[p];
      permute();
    endfunction

    function void note_block(logic [35:0] data, logic [3:0] count, logic last);
      logic [3:0] blk [9];
      int n;
      int done;
      digest_chunk_t c;
      for (int p = 0; p < 9; p++) blk[p] = data[4 * (8 - p) +: 4];
      if (!last) begin
        absorb(blk);
        return;
      end
      n = (count > 9) ? 9 : count;
      if (n == 9) begin
        absorb(blk);
        n = 0;
      end
      blk[n] = PadNibble;
      for (int p = n + 1; p < 9; p++) blk[p] = 0;
      absorb(blk);
      done = 0;
      while (done < 40) begin
        n = (40 - done > 9) ? 9 : 40 - done;
        c.chunk = 0;
        for (int p = 0; p < n; p++) c.chunk[4 * (8 - p) +: 4] = cells[p];
        done += n;
        c.nibbles = 4'(n);
        c.last = (done >= 40);
        pending.push_back(c);
        if (done < 40) permute();
      end
      load_iv();
    endfunction

    function void check_chunk(logic [35:0] chunk, logic [3:0] nib, logic last);
      digest_chunk_t e;
      if (pending.size() == 0) begin
        $error("digest chunk %h arrived with none expected", chunk);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (chunk !== e.chunk) begin
        $error("digest_chunk expected %h actual %h", e.chunk, chunk);
        errors++;
      end
      if (nib !== e.nibbles) begin
        $error("chunk_nibbles expected %0d actual %0d", e.nibbles, nib);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_chunk expected %0d actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [35:0] in_block_data = 0;
  logic [3:0] in_nibble_count = 0;
  logic in_is_last = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [35:0] out_digest_chunk;
  logic [3:0] out_chunk_nibbles;
  logic out_last_chunk;

  digest_scoreboard sb = new();
  int send_idle_pct = 27;
  int recv_idle_pct = 86;
  int hold_cycles = 0;
  longint cycle_count = 0;

  photon160_sponge_hash uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) sb.note_block(in_block_data, in_nibble_count, in_is_last);
    if (rst_n && out_valid && !out_stall)
      sb.check_chunk(out_digest_chunk, out_chunk_nibbles, out_last_chunk);
  end

  // Receiver: a hold-off, when requested, overrides the random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Valid stays high after the transaction until the next call or the drain
  // lowers it, so that it is written only once per falling edge.
  task automatic send_block(logic [35:0] data, logic [3:0] count, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_block_data <= data;
    in_nibble_count <= count;
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [35:0] rand_data();
    return {4'($urandom_range(15)), $urandom()};
  endfunction

  // Mostly short messages, sometimes with a full last block or a count above nine.
  task automatic send_message();
    int len;
    int c;
    len = $urandom_range(3);
    for (int i = 0; i < len; i++) send_block(rand_data(), 4'($urandom_range(15)), 1'b0);
    c = $urandom_range(9);
    if ($urandom_range(9) == 0) c = $urandom_range(15, 10);
    send_block(rand_data(), 4'(c), 1'b1);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    for (int c = 0; c <= 15; c++) send_block(36'h0, 4'(c), 1'b1);
    send_block(36'hF_FFFF_FFFF, 4'd9, 1'b0);
    send_block(36'hF_FFFF_FFFF, 4'd9, 1'b1);
    send_block(36'hA_5A5A_5A5A, 4'd0, 1'b0);
    send_block(36'h5_A5A5_A5A5, 4'd5, 1'b1);
    send_block(36'hF_FFFF_FFFF, 4'd1, 1'b1);

    // Long receiver hold-off so the block fills and stalls its input.
    hold_cycles = 300;
    for (int i = 0; i < 3; i++) send_message();

    for (int i = 0; i < 51; i++) send_message();
    drain();
    send_idle_pct = 86;
    recv_idle_pct = 27;
    for (int i = 0; i < 51; i++) send_message();
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 51; i++) send_message();
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial sb.load_iv();
endmodule

>>> filelist.f
rtl/phot_pkg.sv
rtl/phot_cell.sv
rtl/photon160_sponge_hash.sv
tb/photon160_sponge_hash_test.sv
